[rtl/gcrt_pkg.sv]
// Shared types, register codes and modular arithmetic steps for the Garner CRT block.
package gcrt_pkg;

  localparam int WORD_BITS    = 60;
  localparam int MAX_W        = 62;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [MAX_W-1:0] mw_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PRIME_COUNT,
    REG_PRIME_0,
    REG_PRIME_1,
    REG_PRIME_2,
    REG_TARGET_MODULUS,
    REG_INV_P0_MOD_P1,
    REG_INV_P0P1_MOD_P2
  } reg_idx_t;

  // One double-and-add step: (2r + b*a) mod m, with r, a below m (or all zero).
  function automatic mw_t mod_step(input mw_t r, input mw_t a, input logic b, input mw_t m);
    logic [MAX_W:0] s;
    s = {r, 1'b0};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    if (b) begin
      s = {1'b0, s[MAX_W-1:0]} + {1'b0, a};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
    end
    return s[MAX_W-1:0];
  endfunction

  function automatic mw_t mod_add(input mw_t a, input mw_t b, input mw_t m);
    logic [MAX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[MAX_W-1:0];
  endfunction

  function automatic mw_t mod_sub(input mw_t a, input mw_t b, input mw_t m);
    mw_t d;
    d = (a >= b) ? (a - b) : (a + (m - b));
    return d;
  endfunction

endpackage

[rtl/gcrt_if.sv]
// Handshake interfaces: residue words in, reduced words out, configuration writes.
interface gcrt_in_if #(parameter int W = gcrt_pkg::WORD_BITS);
  logic         valid;
  logic         ready;
  logic [W-1:0] residue_0;
  logic [W-1:0] residue_1;
  logic [W-1:0] residue_2;
  modport source(output valid, output residue_0, output residue_1, output residue_2,
                 input ready);
  modport sink(input valid, input residue_0, input residue_1, input residue_2,
               output ready);
endinterface

interface gcrt_out_if #(parameter int W = gcrt_pkg::WORD_BITS);
  logic         valid;
  logic         ready;
  logic [W-1:0] value_mod_p;
  modport source(output valid, output value_mod_p, input ready);
  modport sink(input valid, input value_mod_p, output ready);
endinterface

interface gcrt_cfg_if #(parameter int W = gcrt_pkg::WORD_BITS);
  logic                                valid;
  logic                                ready;
  logic [gcrt_pkg::CFG_IDX_BITS-1:0]   index;
  logic [W-1:0]                        data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/gcrt_lane.sv]
// Pipelined bit-serial modular multiplier: r = x*a mod m, one bit of x per stage.
module gcrt_lane #(
  parameter int W = gcrt_pkg::WORD_BITS
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] x,
  input  logic [W-1:0] a,
  input  logic [W-1:0] m,
  output logic [W-1:0] r
);

  logic [W-1:0] rs [W];
  logic [W-1:0] xs [W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] r_in;
    logic [W-1:0] x_in;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign x_in = x;
    end else begin : g_rest
      assign r_in = rs[k-1];
      assign x_in = xs[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rs[k] <= W'(gcrt_pkg::mod_step(gcrt_pkg::mw_t'(r_in), gcrt_pkg::mw_t'(a),
                                       x_in[W-1-k], gcrt_pkg::mw_t'(m)));
      end
    end

    if (k < W-1) begin : g_x
      always_ff @(posedge clk) begin
        if (en) begin
          xs[k] <= x_in;
        end
      end
    end
  end

  assign r = rs[W-1];

endmodule

[rtl/gcrt_delay.sv]
// Delay line that keeps side data and its valid bit in step with the lanes.
module gcrt_delay #(
  parameter int N  = gcrt_pkg::WORD_BITS,
  parameter int DW = gcrt_pkg::WORD_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [DW-1:0] din,
  output logic          vout,
  output logic [DW-1:0] dout
);

  logic [N-1:0]  v;
  logic [DW-1:0] d [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], vin};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 0) begin
          d[k] <= din;
        end else begin
          d[k] <= d[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign vout = v[N-1];
  assign dout = d[N-1];

endmodule

[rtl/gcrt_derive.sv]
// Sequencer deriving reduced constants bit-serially after reset and each register write.
module gcrt_derive #(
  parameter int W = gcrt_pkg::WORD_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] prime_0,
  input  logic [W-1:0] prime_1,
  input  logic [W-1:0] prime_2,
  input  logic [W-1:0] target_modulus,
  input  logic [W-1:0] inv_p0_mod_p1,
  input  logic [W-1:0] inv_p0p1_mod_p2,
  output logic         busy,
  output logic [W-1:0] p0_mod_target,
  output logic [W-1:0] p0p1_mod_target,
  output logic [W-1:0] inv1_red,
  output logic [W-1:0] inv2_red,
  output logic [W-1:0] p0_mod_p2
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [2:0] {
    J_P0, J_P1, J_P01, J_INV1, J_INV2, J_P0R2
  } job_t;

  job_t          job;
  logic [CW-1:0] bitc;
  logic [W-1:0]  acc;
  logic [W-1:0]  xs;
  logic [W-1:0]  p1_mod_target;

  logic [W-1:0]  x_sel;
  logic [W-1:0]  a_sel;
  logic [W-1:0]  m_sel;
  logic [W-1:0]  one_p;
  logic [W-1:0]  one_p1;
  logic [W-1:0]  one_p2;
  logic          first;
  logic          last;
  logic          b;
  logic [W-1:0]  acc_next;

  assign one_p  = {{(W-1){1'b0}}, (target_modulus > W'(1))};
  assign one_p1 = {{(W-1){1'b0}}, (prime_1 > W'(1))};
  assign one_p2 = {{(W-1){1'b0}}, (prime_2 > W'(1))};

  always_comb begin
    case (job)
      J_P0: begin
        x_sel = prime_0; a_sel = one_p; m_sel = target_modulus;
      end
      J_P1: begin
        x_sel = prime_1; a_sel = one_p; m_sel = target_modulus;
      end
      J_P01: begin
        x_sel = p1_mod_target; a_sel = p0_mod_target; m_sel = target_modulus;
      end
      J_INV1: begin
        x_sel = inv_p0_mod_p1; a_sel = one_p1; m_sel = prime_1;
      end
      J_INV2: begin
        x_sel = inv_p0p1_mod_p2; a_sel = one_p2; m_sel = prime_2;
      end
      J_P0R2: begin
        x_sel = prime_0; a_sel = one_p2; m_sel = prime_2;
      end
      default: begin
        x_sel = '0; a_sel = '0; m_sel = '0;
      end
    endcase
  end

  assign first    = (bitc == '0);
  assign last     = (bitc == CW'(W-1));
  assign b        = first ? x_sel[W-1] : xs[W-1];
  assign acc_next = W'(gcrt_pkg::mod_step(gcrt_pkg::mw_t'(acc), gcrt_pkg::mw_t'(a_sel), b,
                                          gcrt_pkg::mw_t'(m_sel)));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      job  <= J_P0;
      bitc <= '0;
      acc  <= '0;
    end else if (busy) begin
      acc  <= last ? '0 : acc_next;
      bitc <= last ? '0 : bitc + CW'(1);
      if (last) begin
        case (job)
          J_P0:    job <= J_P1;
          J_P1:    job <= J_P01;
          J_P01:   job <= J_INV1;
          J_INV1:  job <= J_INV2;
          J_INV2:  job <= J_P0R2;
          default: begin
            job  <= J_P0;
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      xs <= (first ? x_sel : xs) << 1;
      if (last) begin
        case (job)
          J_P0:    p0_mod_target   <= acc_next;
          J_P1:    p1_mod_target   <= acc_next;
          J_P01:   p0p1_mod_target <= acc_next;
          J_INV1:  inv1_red        <= acc_next;
          J_INV2:  inv2_red        <= acc_next;
          default: p0_mod_p2       <= acc_next;
        endcase
      end
    end
  end

endmodule

[rtl/garner_crt_reduce_mod_p_top.sv]
// Top level: Garner CRT reconstruction of residue words reduced modulo the target.
// Throughput: one word per cycle while the result is not stalled and derivation is
// idle; eight chained bit-serial modular multiplier stages. A stalled result holds
// the whole pipeline; nothing is lost or repeated. Reset (rst, synchronous) loads
// the register defaults; after reset and after every write to a defined register
// the derivation unit runs with coef.ready low.
module garner_crt_reduce_mod_p_top #(
  parameter int WORD_BITS = gcrt_pkg::WORD_BITS
) (
  input  logic            clk,
  input  logic            rst,
  gcrt_cfg_if.sink        cfg,
  gcrt_in_if.sink         coef,
  gcrt_out_if.source      result
);

  localparam int W = WORD_BITS;

  function automatic logic [W-1:0] add_w(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] m);
    return W'(gcrt_pkg::mod_add(gcrt_pkg::mw_t'(a), gcrt_pkg::mw_t'(b),
                                gcrt_pkg::mw_t'(m)));
  endfunction

  function automatic logic [W-1:0] sub_w(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] m);
    return W'(gcrt_pkg::mod_sub(gcrt_pkg::mw_t'(a), gcrt_pkg::mw_t'(b),
                                gcrt_pkg::mw_t'(m)));
  endfunction

  // configuration
  logic [1:0]   prime_count;
  logic [W-1:0] prime_0;
  logic [W-1:0] prime_1;
  logic [W-1:0] prime_2;
  logic [W-1:0] target_modulus;
  logic [W-1:0] inv_p0_mod_p1;
  logic [W-1:0] inv_p0p1_mod_p2;

  logic cfg_wr;
  logic restart;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign restart   = cfg_wr && (cfg.index <= gcrt_pkg::REG_INV_P0P1_MOD_P2);

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count     <= 2'd1;
      prime_0         <= W'(2);
      prime_1         <= W'(3);
      prime_2         <= W'(5);
      target_modulus  <= W'(2);
      inv_p0_mod_p1   <= '0;
      inv_p0p1_mod_p2 <= '0;
    end else if (cfg_wr) begin
      case (cfg.index)
        gcrt_pkg::REG_PRIME_COUNT:     prime_count     <= cfg.data[1:0];
        gcrt_pkg::REG_PRIME_0:         prime_0         <= cfg.data;
        gcrt_pkg::REG_PRIME_1:         prime_1         <= cfg.data;
        gcrt_pkg::REG_PRIME_2:         prime_2         <= cfg.data;
        gcrt_pkg::REG_TARGET_MODULUS:  target_modulus  <= cfg.data;
        gcrt_pkg::REG_INV_P0_MOD_P1:   inv_p0_mod_p1   <= cfg.data;
        gcrt_pkg::REG_INV_P0P1_MOD_P2: inv_p0p1_mod_p2 <= cfg.data;
        default: ;
      endcase
    end
  end

  // derived constants
  logic         busy;
  logic [W-1:0] p0_mod_target;
  logic [W-1:0] p0p1_mod_target;
  logic [W-1:0] inv1_red;
  logic [W-1:0] inv2_red;
  logic [W-1:0] p0_mod_p2;

  gcrt_derive #(.W(W)) u_derive (
    .clk, .rst, .start(restart),
    .prime_0, .prime_1, .prime_2, .target_modulus, .inv_p0_mod_p1, .inv_p0p1_mod_p2,
    .busy, .p0_mod_target, .p0p1_mod_target, .inv1_red, .inv2_red, .p0_mod_p2
  );

  logic [W-1:0] one_p;
  logic [W-1:0] one_p0;
  logic [W-1:0] one_p1;
  logic [W-1:0] one_p2;

  assign one_p  = {{(W-1){1'b0}}, (target_modulus > W'(1))};
  assign one_p0 = {{(W-1){1'b0}}, (prime_0 > W'(1))};
  assign one_p1 = {{(W-1){1'b0}}, (prime_1 > W'(1))};
  assign one_p2 = {{(W-1){1'b0}}, (prime_2 > W'(1))};

  // handshake
  logic         adv;
  logic         fire;
  logic         out_v;
  logic [W-1:0] out_d;

  assign adv        = !out_v || result.ready;
  assign coef.ready = adv && !busy;
  assign fire       = coef.valid && coef.ready;

  // stage A: a0 = residue_0 mod prime_0
  logic         va;
  logic [W-1:0] a0, ra1, ra2;
  gcrt_lane  #(.W(W)) u_la0 (.clk, .en(adv), .x(coef.residue_0), .a(one_p0), .m(prime_0),
                             .r(a0));
  gcrt_delay #(.N(W), .DW(2*W)) u_da (.clk, .rst, .en(adv), .vin(fire),
                                      .din({coef.residue_1, coef.residue_2}),
                                      .vout(va), .dout({ra1, ra2}));

  // stage B: a0 reduced by p, prime_1, prime_2; residue_1 reduced
  logic         vb;
  logic [W-1:0] a0p, a0p1, a0p2, r1r, rb2;
  gcrt_lane  #(.W(W)) u_lb0 (.clk, .en(adv), .x(a0),  .a(one_p),  .m(target_modulus),
                             .r(a0p));
  gcrt_lane  #(.W(W)) u_lb1 (.clk, .en(adv), .x(a0),  .a(one_p1), .m(prime_1), .r(a0p1));
  gcrt_lane  #(.W(W)) u_lb2 (.clk, .en(adv), .x(a0),  .a(one_p2), .m(prime_2), .r(a0p2));
  gcrt_lane  #(.W(W)) u_lb3 (.clk, .en(adv), .x(ra1), .a(one_p1), .m(prime_1), .r(r1r));
  gcrt_delay #(.N(W), .DW(W)) u_db (.clk, .rst, .en(adv), .vin(va), .din(ra2),
                                    .vout(vb), .dout(rb2));

  // stage C: a1 = (r1 - a0) * inv mod prime_1; residue_2 reduced
  logic         vc;
  logic [W-1:0] d1, a1, r2r, c_a0p, c_a0p2;
  assign d1 = sub_w(r1r, a0p1, prime_1);
  gcrt_lane  #(.W(W)) u_lc0 (.clk, .en(adv), .x(d1),  .a(inv1_red), .m(prime_1), .r(a1));
  gcrt_lane  #(.W(W)) u_lc1 (.clk, .en(adv), .x(rb2), .a(one_p2),   .m(prime_2), .r(r2r));
  gcrt_delay #(.N(W), .DW(2*W)) u_dc (.clk, .rst, .en(adv), .vin(vb), .din({a0p, a0p2}),
                                      .vout(vc), .dout({c_a0p, c_a0p2}));

  // stage D: a1 reduced by p and prime_2
  logic         vd;
  logic [W-1:0] a1p, a1p2, d_a0p, d_a0p2, d_r2r;
  gcrt_lane  #(.W(W)) u_ld0 (.clk, .en(adv), .x(a1), .a(one_p),  .m(target_modulus),
                             .r(a1p));
  gcrt_lane  #(.W(W)) u_ld1 (.clk, .en(adv), .x(a1), .a(one_p2), .m(prime_2), .r(a1p2));
  gcrt_delay #(.N(W), .DW(3*W)) u_dd (.clk, .rst, .en(adv), .vin(vc),
                                      .din({c_a0p, c_a0p2, r2r}),
                                      .vout(vd), .dout({d_a0p, d_a0p2, d_r2r}));

  // stage E: a1*p0 mod p and mod prime_2
  logic         ve;
  logic [W-1:0] m1, m2, e_a0p, e_a0p2, e_r2r;
  gcrt_lane  #(.W(W)) u_le0 (.clk, .en(adv), .x(a1p),  .a(p0_mod_target), .m(target_modulus),
                             .r(m1));
  gcrt_lane  #(.W(W)) u_le1 (.clk, .en(adv), .x(a1p2), .a(p0_mod_p2), .m(prime_2), .r(m2));
  gcrt_delay #(.N(W), .DW(3*W)) u_de (.clk, .rst, .en(adv), .vin(vd),
                                      .din({d_a0p, d_a0p2, d_r2r}),
                                      .vout(ve), .dout({e_a0p, e_a0p2, e_r2r}));

  // stage F: a2 = (r2 - (a0 + a1*p0)) * inv mod prime_2
  logic         vf;
  logic [W-1:0] racc, t2, d2, a2, f_racc;
  assign racc = prime_count[1] ? add_w(e_a0p, m1, target_modulus) : e_a0p;
  assign t2   = add_w(e_a0p2, m2, prime_2);
  assign d2   = sub_w(e_r2r, t2, prime_2);
  gcrt_lane  #(.W(W)) u_lf (.clk, .en(adv), .x(d2), .a(inv2_red), .m(prime_2), .r(a2));
  gcrt_delay #(.N(W), .DW(W)) u_df (.clk, .rst, .en(adv), .vin(ve), .din(racc),
                                    .vout(vf), .dout(f_racc));

  // stage G: a2 mod p
  logic         vg;
  logic [W-1:0] a2p, g_racc;
  gcrt_lane  #(.W(W)) u_lg (.clk, .en(adv), .x(a2), .a(one_p), .m(target_modulus), .r(a2p));
  gcrt_delay #(.N(W), .DW(W)) u_dg (.clk, .rst, .en(adv), .vin(vf), .din(f_racc),
                                    .vout(vg), .dout(g_racc));

  // stage H: a2 * p0p1 mod p
  logic         vh;
  logic [W-1:0] m3, h_racc, res;
  gcrt_lane  #(.W(W)) u_lh (.clk, .en(adv), .x(a2p), .a(p0p1_mod_target),
                            .m(target_modulus), .r(m3));
  gcrt_delay #(.N(W), .DW(W)) u_dh (.clk, .rst, .en(adv), .vin(vg), .din(g_racc),
                                    .vout(vh), .dout(h_racc));

  assign res = (prime_count == 2'd3) ? add_w(h_racc, m3, target_modulus) : h_racc;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= res;
    end
  end

  assign result.valid       = out_v;
  assign result.value_mod_p = out_d;

  // checks
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((target_modulus < W'(2)) ? (result.value_mod_p == '0)
                                               : (result.value_mod_p < target_modulus)))
    else $error("result word not reduced");

  a_const_range: assert property (@(posedge clk) disable iff (rst)
    (!busy && (target_modulus > W'(1))) |-> (p0_mod_target < target_modulus &&
                                              p0p1_mod_target < target_modulus))
    else $error("derived constant not reduced");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    restart |=> busy)
    else $error("derivation not restarted after write");

endmodule
